FILE: sv/nls_pkg.sv
// Shared types, character codes and default sizes for the numeric literal scanner.
package nls_pkg;

  localparam int unsigned INT_BITS_DEF      = 64;
  localparam int unsigned FRACTION_BITS_DEF = 32;
  localparam int unsigned DIGIT_POS_W       = 4;
  localparam logic [DIGIT_POS_W-1:0] FRAC_DIGITS_MAX = 4'd10;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_LO_O  = 8'h6f;
  localparam logic [7:0] CH_UP_O  = 8'h4f;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [3:0] HEX_TEN  = 4'ha;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ZERO = 3'd1,
    PH_BIN  = 3'd2,
    PH_OCT  = 3'd3,
    PH_DEC  = 3'd4,
    PH_HEX  = 3'd5,
    PH_FRAC = 3'd6
  } phase_t;

  // Classification of one source character.
  typedef struct packed {
    logic       is_zero;
    logic       is_dec;
    logic       is_bin;
    logic       is_oct;
    logic       is_hex;
    logic       is_dot;
    logic       is_b;
    logic       is_o;
    logic       is_x;
    logic [3:0] value;
  } char_class_t;

endpackage

FILE: sv/nls_if.sv
// Valid/ready channel interfaces for the scanner's character input and literal output.
interface nls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       begins_literal;

  modport source (output valid, output character, output begins_literal, input ready);
  modport sink   (input valid, input character, input begins_literal, output ready);
endinterface

interface nls_out_if import nls_pkg::*; #(
  parameter int unsigned INT_BITS      = INT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [INT_BITS-1:0]      int_value;
  logic [FRACTION_BITS-1:0] fraction;

  modport source (output valid, output kind, output int_value, output fraction, input ready);
  modport sink   (input valid, input kind, input int_value, input fraction, output ready);
endinterface

FILE: sv/nls_char_class.sv
// Character classifier: digit classes, radix letters and the digit value of one byte.
module nls_char_class import nls_pkg::*; (
  input  logic [7:0]  character,
  output char_class_t cls
);

  logic is_lo_hex;
  logic is_up_hex;

  always_comb begin
    is_lo_hex   = (character >= CH_LO_A) && (character <= CH_LO_F);
    is_up_hex   = (character >= CH_UP_A) && (character <= CH_UP_F);
    cls.is_zero = (character == CH_0);
    cls.is_dec  = (character >= CH_0) && (character <= CH_9);
    cls.is_bin  = (character == CH_0) || (character == CH_1);
    cls.is_oct  = (character >= CH_0) && (character <= CH_7);
    cls.is_hex  = cls.is_dec || is_lo_hex || is_up_hex;
    cls.is_dot  = (character == CH_DOT);
    cls.is_b    = (character == CH_LO_B) || (character == CH_UP_B);
    cls.is_o    = (character == CH_LO_O) || (character == CH_UP_O);
    cls.is_x    = (character == CH_LO_X) || (character == CH_UP_X);
    if (is_lo_hex) begin
      cls.value = 4'(character - CH_LO_A) + HEX_TEN;
    end else if (is_up_hex) begin
      cls.value = 4'(character - CH_UP_A) + HEX_TEN;
    end else begin
      cls.value = 4'(character - CH_0);
    end
  end

endmodule

FILE: sv/numeric_literal_scanner.sv
// Numeric literal scanner: one character per beat in, one literal value out per literal.
// A character beat is held in the input register until the scan stage takes it; a
// result it ends is loaded into the output register and presented on the output channel.
// Throughput: one character beat per cycle while the output register can take a result,
// set by the single scan stage whose state registers (phase, accumulator, fraction sum) feed back to it.
// Reset: synchronous, active low; both channel registers empty and the scanner idle.
module numeric_literal_scanner import nls_pkg::*; #(
  parameter int unsigned INT_BITS      = INT_BITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  nls_in_if.sink    in_port,
  nls_out_if.source out_port
);

  // Weight of one unit at fraction position k is floor(2^F / 10^k). These are
  // worked out at elaboration; 2^F is never a multiple of 10^k, so the quotient
  // is already the floor the scan needs.
  localparam logic [63:0] POW2F = 64'd1 << FRACTION_BITS;
  localparam logic [FRACTION_BITS-1:0] STEP_1  = FRACTION_BITS'(POW2F / 64'd10);
  localparam logic [FRACTION_BITS-1:0] STEP_2  = FRACTION_BITS'(POW2F / 64'd100);
  localparam logic [FRACTION_BITS-1:0] STEP_3  = FRACTION_BITS'(POW2F / 64'd1000);
  localparam logic [FRACTION_BITS-1:0] STEP_4  = FRACTION_BITS'(POW2F / 64'd10000);
  localparam logic [FRACTION_BITS-1:0] STEP_5  = FRACTION_BITS'(POW2F / 64'd100000);
  localparam logic [FRACTION_BITS-1:0] STEP_6  = FRACTION_BITS'(POW2F / 64'd1000000);
  localparam logic [FRACTION_BITS-1:0] STEP_7  = FRACTION_BITS'(POW2F / 64'd10000000);
  localparam logic [FRACTION_BITS-1:0] STEP_8  = FRACTION_BITS'(POW2F / 64'd100000000);
  localparam logic [FRACTION_BITS-1:0] STEP_9  = FRACTION_BITS'(POW2F / 64'd1000000000);
  localparam logic [FRACTION_BITS-1:0] STEP_10 = FRACTION_BITS'(POW2F / 64'd10000000000);

  // Input register: holds one character beat until the scan stage takes it.
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_begins_r;

  // Scanner state.
  phase_t                   phase_r,  phase_nxt;
  logic [INT_BITS-1:0]      acc_r,    acc_nxt;
  logic [FRACTION_BITS-1:0] fsum_r,   fsum_nxt;
  logic [DIGIT_POS_W-1:0]   dpos_r,   dpos_nxt;

  // Output register.
  logic                     out_v_r;
  logic                     out_kind_r;
  logic [INT_BITS-1:0]      out_int_r;
  logic [FRACTION_BITS-1:0] out_frac_r;

  char_class_t              cls;
  logic                     fire;
  logic                     in_accept;
  logic                     emit;
  logic                     active;
  logic [DIGIT_POS_W-1:0]   dpos_inc;
  logic [FRACTION_BITS-1:0] step;
  logic [FRACTION_BITS+3:0] frac_prod;
  logic [INT_BITS-1:0]      dig_ext;

  nls_char_class u_char_class (
    .character (in_char_r),
    .cls       (cls)
  );

  // The scan stage moves whenever the output register can take a possible result.
  assign fire      = in_v_r && (!out_v_r || out_port.ready);
  assign in_port.ready = !in_v_r || fire;
  assign in_accept = in_port.valid && in_port.ready;

  assign dpos_inc  = dpos_r + 1'b1;
  assign dig_ext   = INT_BITS'(cls.value);
  assign frac_prod = {{FRACTION_BITS{1'b0}}, cls.value} * {4'b0000, step};

  always_comb begin
    case (dpos_inc)
      4'd1:    step = STEP_1;
      4'd2:    step = STEP_2;
      4'd3:    step = STEP_3;
      4'd4:    step = STEP_4;
      4'd5:    step = STEP_5;
      4'd6:    step = STEP_6;
      4'd7:    step = STEP_7;
      4'd8:    step = STEP_8;
      4'd9:    step = STEP_9;
      4'd10:   step = STEP_10;
      default: step = '0;
    endcase
  end

  // Next state of the scanner and whether this character ends a literal. The
  // ending character is not consumed: if it does not start a new literal it is
  // simply dropped after the current literal is emitted.
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    fsum_nxt  = fsum_r;
    dpos_nxt  = dpos_r;
    emit      = 1'b0;

    case (phase_r)
      PH_ZERO, PH_BIN, PH_OCT, PH_DEC, PH_HEX, PH_FRAC: active = 1'b1;
      default:                                          active = 1'b0;
    endcase

    if (in_begins_r) begin
      // A new literal starts here; any literal in progress is emitted first.
      emit     = active;
      acc_nxt  = '0;
      fsum_nxt = '0;
      dpos_nxt = '0;
      if (cls.is_zero) begin
        phase_nxt = PH_ZERO;
      end else if (cls.is_dec) begin
        phase_nxt = PH_DEC;
        acc_nxt   = dig_ext;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_ZERO: begin
          if (cls.is_b) begin
            phase_nxt = PH_BIN;
          end else if (cls.is_o) begin
            phase_nxt = PH_OCT;
          end else if (cls.is_x) begin
            phase_nxt = PH_HEX;
          end else if (cls.is_dot) begin
            phase_nxt = PH_FRAC;
          end else begin
            emit = 1'b1;
          end
        end
        PH_BIN: begin
          if (cls.is_bin) begin
            acc_nxt = {acc_r[INT_BITS-2:0], cls.value[0]};
          end else begin
            emit = 1'b1;
          end
        end
        PH_OCT: begin
          if (cls.is_oct) begin
            acc_nxt = {acc_r[INT_BITS-4:0], cls.value[2:0]};
          end else begin
            emit = 1'b1;
          end
        end
        PH_DEC: begin
          if (cls.is_dec) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + dig_ext;
          end else if (cls.is_dot) begin
            phase_nxt = PH_FRAC;
          end else begin
            emit = 1'b1;
          end
        end
        PH_HEX: begin
          if (cls.is_hex) begin
            acc_nxt = {acc_r[INT_BITS-5:0], cls.value};
          end else begin
            emit = 1'b1;
          end
        end
        PH_FRAC: begin
          if (cls.is_dec) begin
            // Digits past the tenth fraction position carry no weight.
            if (dpos_r < FRAC_DIGITS_MAX) begin
              dpos_nxt = dpos_inc;
              fsum_nxt = fsum_r + frac_prod[FRACTION_BITS-1:0];
            end
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          // Idle, or an unused phase code that behaves as idle.
          phase_nxt = PH_IDLE;
        end
      endcase

      if (emit) begin
        phase_nxt = PH_IDLE;
        acc_nxt   = '0;
        fsum_nxt  = '0;
        dpos_nxt  = '0;
      end
    end
  end

  // Control and scanner state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      fsum_r  <= '0;
      dpos_r  <= '0;
    end else begin
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end

      if (fire && emit) begin
        out_v_r <= 1'b1;
      end else if (out_port.ready) begin
        out_v_r <= 1'b0;
      end

      if (fire) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        fsum_r  <= fsum_nxt;
        dpos_r  <= dpos_nxt;
      end
    end
  end

  // Payload registers; the result reflects the literal as it stood before this beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_char_r   <= in_port.character;
      in_begins_r <= in_port.begins_literal;
    end
    if (fire && emit) begin
      out_kind_r <= (phase_r == PH_FRAC);
      out_int_r  <= acc_r;
      out_frac_r <= (phase_r == PH_FRAC) ? fsum_r : '0;
    end
  end

  assign out_port.valid     = out_v_r;
  assign out_port.kind      = out_kind_r;
  assign out_port.int_value = out_int_r;
  assign out_port.fraction  = out_frac_r;

endmodule
